FILE: design/mnmp_pkg.sv
package mnmp_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'b001,
    MODE_COLLECT = 3'b010,
    MODE_DISCARD = 3'b100
  } parse_mode_e;

  localparam logic [1:0] KIND_NOTE_OFF   = 2'd0;
  localparam logic [1:0] KIND_NOTE_ON    = 2'd1;
  localparam logic [1:0] KIND_DATA_ERR   = 2'd2;
  localparam logic [1:0] KIND_STATUS_ERR = 2'd3;

  localparam logic [3:0] CMD_NOTE_OFF = 4'h8;
  localparam logic [3:0] CMD_NOTE_ON  = 4'h9;

  localparam logic [1:0] DATA_BYTES = 2'd2;

endpackage

FILE: design/midi_note_message_parser.sv
// midi note-on / note-off parser, one midi byte per input word
// input channel: byte_in_i with byte_in_valid_i / byte_in_ready_o; bit 7 set marks
//   a status byte
// output channel: event_kind_o, channel_o, key_o, velocity_o with event_valid_o /
//   event_ready_i; kind 0 note off, 1 note on, 2 data byte where a status byte
//   was expected, 3 status byte inside a message (error words carry zero fields)
// a note word is registered when its velocity byte is accepted, an error
// word when the offending byte is; other bytes give no word
// throughput is one byte per cycle unless the output stalls; the parse state
// and the single output register both update in the cycle the byte is taken
// the output register holds a word until the receiver takes it; while it holds
// an untaken word and event_ready_i is low, byte_in_ready_o is low, so a stall
// costs exactly the cycles the receiver waits
// reset (rst_ni low, asynchronous) returns the parser to idle with nothing held
// and no output word pending
module midi_note_message_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       byte_in_valid_i,
  output logic       byte_in_ready_o,
  input  logic [7:0] byte_in_i,
  output logic       event_valid_o,
  input  logic       event_ready_i,
  output logic [1:0] event_kind_o,
  output logic [3:0] channel_o,
  output logic [6:0] key_o,
  output logic [6:0] velocity_o
);

  mnmp_pkg::parse_mode_e mode_q, mode_d;
  logic       is_note_on_q, is_note_on_d;
  logic [3:0] held_channel_q, held_channel_d;
  logic [6:0] held_key_q, held_key_d;
  logic [1:0] data_count_q, data_count_d;

  logic       out_valid_q;
  logic [1:0] kind_q, kind_d;
  logic [3:0] chan_q, chan_d;
  logic [6:0] key_q, key_d;
  logic [6:0] vel_q, vel_d;

  logic       accept;
  logic       emit;
  logic       is_status;
  logic [3:0] cmd;
  logic [1:0] count_inc;

  assign byte_in_ready_o = !out_valid_q || event_ready_i;
  assign accept          = byte_in_valid_i && byte_in_ready_o;
  assign is_status       = byte_in_i[7];
  assign cmd             = byte_in_i[7:4];
  assign count_inc       = data_count_q + 2'd1;

  always_comb begin
    mode_d         = mode_q;
    is_note_on_d   = is_note_on_q;
    held_channel_d = held_channel_q;
    held_key_d     = held_key_q;
    data_count_d   = data_count_q;
    emit           = 1'b0;
    kind_d         = mnmp_pkg::KIND_NOTE_OFF;
    chan_d         = '0;
    key_d          = '0;
    vel_d          = '0;
    case (mode_q)
      mnmp_pkg::MODE_COLLECT: begin
        if (is_status) begin
          mode_d = mnmp_pkg::MODE_IDLE;
          emit   = 1'b1;
          kind_d = mnmp_pkg::KIND_STATUS_ERR;
        end else begin
          data_count_d = count_inc;
          if (count_inc == 2'd1) begin
            held_key_d = byte_in_i[6:0];
          end else if (count_inc >= mnmp_pkg::DATA_BYTES) begin
            mode_d = mnmp_pkg::MODE_IDLE;
            emit   = 1'b1;
            kind_d = is_note_on_q ? mnmp_pkg::KIND_NOTE_ON : mnmp_pkg::KIND_NOTE_OFF;
            chan_d = held_channel_q;
            key_d  = held_key_q;
            vel_d  = byte_in_i[6:0];
          end
        end
      end
      default: begin
        // idle, and discarding once a status byte turns up
        if (!is_status) begin
          if (mode_q != mnmp_pkg::MODE_DISCARD) begin
            mode_d = mnmp_pkg::MODE_IDLE;
            emit   = 1'b1;
            kind_d = mnmp_pkg::KIND_DATA_ERR;
          end
        end else begin
          held_channel_d = byte_in_i[3:0];
          if (cmd == mnmp_pkg::CMD_NOTE_OFF || cmd == mnmp_pkg::CMD_NOTE_ON) begin
            is_note_on_d = (cmd == mnmp_pkg::CMD_NOTE_ON);
            data_count_d = '0;
            mode_d       = mnmp_pkg::MODE_COLLECT;
          end else begin
            mode_d = mnmp_pkg::MODE_DISCARD;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= mnmp_pkg::MODE_IDLE;
      is_note_on_q   <= 1'b0;
      held_channel_q <= '0;
      held_key_q     <= '0;
      data_count_q   <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (accept) begin
        mode_q         <= mode_d;
        is_note_on_q   <= is_note_on_d;
        held_channel_q <= held_channel_d;
        held_key_q     <= held_key_d;
        data_count_q   <= data_count_d;
        out_valid_q    <= emit;
      end else if (event_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      kind_q <= kind_d;
      chan_q <= chan_d;
      key_q  <= key_d;
      vel_q  <= vel_d;
    end
  end

  assign event_valid_o = out_valid_q;
  assign event_kind_o  = kind_q;
  assign channel_o     = chan_q;
  assign key_o         = key_q;
  assign velocity_o    = vel_q;

  a_data_in_idle_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && mode_q == mnmp_pkg::MODE_IDLE && !byte_in_i[7])
      |=> (event_valid_o && event_kind_o == mnmp_pkg::KIND_DATA_ERR))
    else $error("data byte in idle gave no error word");

  a_status_in_msg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && mode_q == mnmp_pkg::MODE_COLLECT && byte_in_i[7])
      |=> (mode_q == mnmp_pkg::MODE_IDLE && event_valid_o
           && event_kind_o == mnmp_pkg::KIND_STATUS_ERR))
    else $error("status byte inside message not flagged");

  a_note_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && mode_q != mnmp_pkg::MODE_COLLECT && byte_in_i[7:4] == mnmp_pkg::CMD_NOTE_ON)
      |=> (mode_q == mnmp_pkg::MODE_COLLECT && is_note_on_q && data_count_q == 2'd0))
    else $error("note on status did not start collecting");

  a_err_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (event_valid_o && event_kind_o[1])
      |-> (channel_o == 4'd0 && key_o == 7'd0 && velocity_o == 7'd0))
    else $error("error word carries non-zero fields");

endmodule
